// ===== hdl/aabb_affine_transform_unit_defines.svh =====
// Assertion macros shared by the block's modules.
`ifndef AABB_AFFINE_TRANSFORM_UNIT_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define AAT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication, checked at every clock edge outside reset.
`define AAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition on one edge that forces another condition on the next edge.
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aat_pkg.sv =====
package aat_pkg;

    localparam int FRAC_BITS = 16;

    localparam int PROD_W = 64;
    localparam int ACC_W  = 50;
    localparam int SQ_W   = 64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BOX  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  row_index;
        logic signed [31:0] coef_x;
        logic signed [31:0] coef_y;
        logic signed [31:0] coef_z;
        logic signed [31:0] coef_t;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0] half_x;
        logic [30:0] half_y;
        logic [30:0] half_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic [30:0] ext_x;
        logic [30:0] ext_y;
        logic [30:0] ext_z;
        logic [30:0] radius;
    } t_out_item;

    // Controller -> datapath commands.
    typedef struct packed {
        logic       capture;    // latch the input item
        logic       load_row;   // write the captured row into the matrix
        logic       row_init;   // start a row: acc = T, eacc = 0
        logic       mul;        // multiply M[row][col] by c/e
        logic       accum;      // add the registered products
        logic       row_done;   // saturate and store row results
        logic [1:0] row;
        logic [1:0] col;
        logic       sq_init;    // start sum of squares
        logic       sq_mul;     // square ext[row]
        logic       sq_acc;     // accumulate the square
        logic       rt_init;    // start the square root
        logic       rt_step;    // one root iteration
        logic       finish;     // build the result item
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_box;
        logic row_ok;
    } t_dp_stat;

    function automatic logic signed [31:0] sat_s32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = ~hi;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

// ===== hdl/aat_datapath.sv =====
`include "aabb_affine_transform_unit_defines.svh"

module aat_datapath
    import aat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_result
);

    t_in_item r_item;
    logic signed [31:0] r_mat [12];

    // shared multipliers: one signed for the center, one unsigned for extents
    logic signed [PROD_W-1:0] r_pc;
    logic [PROD_W-1:0]        r_pe;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]         r_eacc;
    logic signed [31:0] r_cn [3];
    logic [30:0]        r_en [3];

    logic [SQ_W-1:0] r_sqp;
    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    t_out_item r_out;

    logic [3:0]  w_idx;
    logic signed [31:0] w_m;
    logic [31:0]        w_am;
    logic signed [31:0] w_c;
    logic [30:0]        w_e;
    logic signed [ACC_W-1:0] w_csh;
    logic [ACC_W-1:0]        w_esh;
    logic [SQ_W-1:0]    w_trial;

    assign w_idx = {i_cmd.row, 2'b00} + {2'b00, i_cmd.col};
    assign w_m   = r_mat[w_idx];
    assign w_am  = w_m[31] ? 32'(-w_m) : w_m;

    always_comb begin
        unique case (i_cmd.col)
            2'd0:    begin w_c = r_item.center_x; w_e = r_item.half_x; end
            2'd1:    begin w_c = r_item.center_y; w_e = r_item.half_y; end
            default: begin w_c = r_item.center_z; w_e = r_item.half_z; end
        endcase
    end

    // arithmetic shift floors toward minus infinity
    assign w_csh   = ACC_W'(r_pc >>> FRAC_BITS);
    assign w_esh   = ACC_W'(r_pe >> FRAC_BITS);
    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 12; k++) begin
                r_mat[k] <= '0;
            end
        end else if (i_cmd.load_row && r_item.row_index != 2'd3) begin
            r_mat[{r_item.row_index, 2'd0}] <= r_item.coef_x;
            r_mat[{r_item.row_index, 2'd1}] <= r_item.coef_y;
            r_mat[{r_item.row_index, 2'd2}] <= r_item.coef_z;
            r_mat[{r_item.row_index, 2'd3}] <= r_item.coef_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.mul) begin
            r_pc <= PROD_W'(w_m) * PROD_W'(w_c);
            r_pe <= PROD_W'(w_am) * PROD_W'(w_e);
        end
        if (i_cmd.row_init) begin
            r_acc  <= ACC_W'(r_mat[{i_cmd.row, 2'd3}]);
            r_eacc <= '0;
        end else if (i_cmd.accum) begin
            r_acc  <= r_acc + w_csh;
            r_eacc <= r_eacc + w_esh;
        end
        if (i_cmd.row_done) begin
            r_cn[i_cmd.row] <= sat_s32(r_acc);
            r_en[i_cmd.row] <= (r_eacc > ACC_W'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                                 : r_eacc[30:0];
        end
        if (i_cmd.sq_mul) begin
            r_sqp <= SQ_W'(r_en[i_cmd.row]) * SQ_W'(r_en[i_cmd.row]);
        end
        if (i_cmd.sq_init) begin
            r_sq <= '0;
        end else if (i_cmd.sq_acc) begin
            r_sq <= r_sq + r_sqp;
        end
        // bit-pair restoring root, starts at the top pair
        if (i_cmd.rt_init) begin
            r_rem <= r_sq;
            r_res <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_cmd.rt_step) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.finish) begin
            r_out.min_x  <= sat_s32(ACC_W'(r_cn[0]) - ACC_W'(r_en[0]));
            r_out.min_y  <= sat_s32(ACC_W'(r_cn[1]) - ACC_W'(r_en[1]));
            r_out.min_z  <= sat_s32(ACC_W'(r_cn[2]) - ACC_W'(r_en[2]));
            r_out.max_x  <= sat_s32(ACC_W'(r_cn[0]) + ACC_W'(r_en[0]));
            r_out.max_y  <= sat_s32(ACC_W'(r_cn[1]) + ACC_W'(r_en[1]));
            r_out.max_z  <= sat_s32(ACC_W'(r_cn[2]) + ACC_W'(r_en[2]));
            r_out.ext_x  <= r_en[0];
            r_out.ext_y  <= r_en[1];
            r_out.ext_z  <= r_en[2];
            r_out.radius <= r_res[31:1];
        end
    end

    assign o_stat.cmd_box = (r_item.cmd == CMD_BOX);
    assign o_stat.row_ok  = (r_item.row_index != 2'd3);
    assign o_result       = r_out;

    `AAT_ASSERT_IMPL(a_root_bit_pos, i_clk, i_rst_n, i_cmd.rt_step, $onehot0(r_bit), "root bit not one-hot")
    `AAT_ASSERT_NEXT(a_init_clears, i_clk, i_rst_n, i_cmd.rt_init, r_res == '0, "root not cleared")
    `AAT_ASSERT_IMPL(a_ext_range, i_clk, i_rst_n, i_cmd.finish, r_res[SQ_W-1:32] == '0, "root too wide")

endmodule

// ===== hdl/aat_ctrl.sv =====
`include "aabb_affine_transform_unit_defines.svh"

module aat_ctrl
    import aat_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output logic     o_done,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_LOAD, S_ROW, S_MUL, S_ACC, S_ROWEND,
        S_SQMUL, S_SQACC, S_RTINIT, S_ROOT, S_FINISH, S_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic [4:0] r_step;
    logic       r_done;
    logic       w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE:   if (i_start) r_state <= S_DECODE;
                S_DECODE: begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_state <= i_stat.cmd_box ? S_ROW : S_LOAD;
                end
                S_LOAD:   r_state <= S_IDLE;
                S_ROW:    r_state <= S_MUL;
                S_MUL:    r_state <= S_ACC;
                S_ACC: begin
                    if (r_col == 2'd2) begin
                        r_col   <= '0;
                        r_state <= S_ROWEND;
                    end else begin
                        r_col   <= r_col + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_ROWEND: begin
                    if (r_row == 2'd2) begin
                        r_row   <= '0;
                        r_state <= S_SQMUL;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_ROW;
                    end
                end
                S_SQMUL:  r_state <= S_SQACC;
                S_SQACC: begin
                    if (r_row == 2'd2) begin
                        r_row   <= '0;
                        r_state <= S_RTINIT;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_SQMUL;
                    end
                end
                S_RTINIT: begin
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) r_state <= S_FINISH;
                end
                S_FINISH: r_state <= S_DONE;
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.row      = r_row;
        o_cmd.col      = r_col;
        o_cmd.capture  = w_accept;
        o_cmd.load_row = (r_state == S_LOAD) && i_stat.row_ok;
        o_cmd.row_init = (r_state == S_ROW) || (r_state == S_DECODE && i_stat.cmd_box);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.accum    = (r_state == S_ACC);
        o_cmd.row_done = (r_state == S_ROWEND);
        o_cmd.sq_init  = (r_state == S_DECODE);
        o_cmd.sq_mul   = (r_state == S_SQMUL);
        o_cmd.sq_acc   = (r_state == S_SQACC);
        o_cmd.rt_init  = (r_state == S_RTINIT);
        o_cmd.rt_step  = (r_state == S_ROOT);
        o_cmd.finish   = (r_state == S_FINISH);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    `AAT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, o_busy, "accept did not raise busy")
    `AAT_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !o_busy || $past(r_state) == S_DONE, "done out of place")
    `AAT_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done longer than a cycle")

endmodule

// ===== hdl/aabb_affine_transform_unit.sv =====
// Box transform unit: a load passes through decode and load states while busy, gives no result,
// and then returns to idle, where the next item can be accepted.
// A box passes through these states before o_done rises and the result is taken:
// decode, three rows of 3 multiply/add pairs on one signed 32x32 and one unsigned 32x31
// multiplier, 3 squaring pairs, root setup, 32 root iterations, finish, done.
// One item at a time, receiver cannot stall; synchronous active-low reset zeroes the matrix.
module aabb_affine_transform_unit
    import aat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: decode, load, row loops, squares, root
    aat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    // matrix store, shared multipliers, accumulators and root unit
    aat_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule

// ===== verif/aabb_box_checker.sv =====
module aabb_box_checker
    import aat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      busy,
    input  t_in_item  i_item,
    input  logic      o_done,
    input  t_out_item o_result,
    output int        o_fail_count,
    output int        o_pending
);

    logic signed [31:0] matrix_words [12];
    t_out_item          box_expected [$];

    // floor(p / 2^FRAC_BITS) on a signed product
    function automatic logic signed [95:0] floor_scale(input logic signed [95:0] p);
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [95:0] clamp_s32(input logic signed [95:0] v);
        if (v > 96'sh7FFF_FFFF) return 96'sh7FFF_FFFF;
        if (v < -96'sh8000_0000) return -96'sh8000_0000;
        return v;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_out_item transform_box(input t_in_item it);
        t_out_item r;
        logic signed [95:0] cen [3];
        logic signed [95:0] acc;
        logic signed [95:0] m;
        logic [95:0] eacc;
        logic [95:0] am;
        logic [30:0] ext [3];
        logic [30:0] half [3];
        logic [63:0] sq;
        logic signed [95:0] lo;
        logic signed [95:0] hi;
        logic signed [95:0] cv [3];
        cv[0] = it.center_x;
        cv[1] = it.center_y;
        cv[2] = it.center_z;
        half[0] = it.half_x;
        half[1] = it.half_y;
        half[2] = it.half_z;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            acc = matrix_words[i*4+3];
            eacc = 0;
            for (int j = 0; j < 3; j++) begin
                m = matrix_words[i*4+j];
                am = (m < 0) ? -m : m;
                acc += floor_scale(m * cv[j]);
                eacc += (am * {65'd0, half[j]}) >> FRAC_BITS;
            end
            cen[i] = clamp_s32(acc);
            ext[i] = (eacc > 96'h7FFF_FFFF) ? 31'h7FFF_FFFF : eacc[30:0];
            sq += {33'd0, ext[i]} * {33'd0, ext[i]};
        end
        lo = clamp_s32(cen[0] - ext[0]);
        hi = clamp_s32(cen[0] + ext[0]);
        r.min_x = lo[31:0];
        r.max_x = hi[31:0];
        lo = clamp_s32(cen[1] - ext[1]);
        hi = clamp_s32(cen[1] + ext[1]);
        r.min_y = lo[31:0];
        r.max_y = hi[31:0];
        lo = clamp_s32(cen[2] - ext[2]);
        hi = clamp_s32(cen[2] + ext[2]);
        r.min_z = lo[31:0];
        r.max_z = hi[31:0];
        r.ext_x = ext[0];
        r.ext_y = ext[1];
        r.ext_z = ext[2];
        r.radius = 31'(floor_root(sq) >> 1);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            for (int k = 0; k < 12; k++) matrix_words[k] = '0;
        end else begin
            if (o_done) begin
                if (box_expected.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, o_result);
                    o_fail_count++;
                end else begin
                    exp_r = box_expected.pop_front();
                    check_field("min_x", exp_r.min_x, o_result.min_x);
                    check_field("min_y", exp_r.min_y, o_result.min_y);
                    check_field("min_z", exp_r.min_z, o_result.min_z);
                    check_field("max_x", exp_r.max_x, o_result.max_x);
                    check_field("max_y", exp_r.max_y, o_result.max_y);
                    check_field("max_z", exp_r.max_z, o_result.max_z);
                    check_field("ext_x", exp_r.ext_x, o_result.ext_x);
                    check_field("ext_y", exp_r.ext_y, o_result.ext_y);
                    check_field("ext_z", exp_r.ext_z, o_result.ext_z);
                    check_field("radius", exp_r.radius, o_result.radius);
                end
            end
            if (start && !busy) begin
                if (i_item.cmd == CMD_BOX) begin
                    box_expected.push_back(transform_box(i_item));
                end else if (i_item.row_index != 2'd3) begin
                    matrix_words[i_item.row_index*4+0] = i_item.coef_x;
                    matrix_words[i_item.row_index*4+1] = i_item.coef_y;
                    matrix_words[i_item.row_index*4+2] = i_item.coef_z;
                    matrix_words[i_item.row_index*4+3] = i_item.coef_t;
                end
            end
        end
        o_pending = box_expected.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench
    import aat_pkg::*;
();

    // Give the tail of the last box a comfortable margin.
    localparam int DRAIN_CYCLES = 80;
    // Worst run: ~1700 items plus idling, many times over.
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;
    int        fail_count;
    int        pending;
    int        cycle_count;
    int        idle_pct;

    aabb_affine_transform_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    aabb_box_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        unique case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return $urandom_range(0, 3) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_half();
        unique case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'd0;
            2: return 31'($urandom_range(0, 64 << 16));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_row(input logic [1:0] row, input logic [31:0] cx,
                                          input logic [31:0] cy, input logic [31:0] cz,
                                          input logic [31:0] ct);
        t_in_item it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.row_index = row;
        it.coef_x = cx;
        it.coef_y = cy;
        it.coef_z = cz;
        it.coef_t = ct;
        // unused box fields carry noise on a load
        it.center_x = $urandom;
        it.half_x = 31'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_box(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [30:0] hx,
                                          input logic [30:0] hy, input logic [30:0] hz);
        t_in_item it;
        it = '0;
        it.cmd = CMD_BOX;
        it.row_index = 2'($urandom);
        it.coef_x = $urandom;  // ignored on a box
        it.center_x = x;
        it.center_y = y;
        it.center_z = z;
        it.half_x = hx;
        it.half_y = hy;
        it.half_z = hz;
        return it;
    endfunction

    // Present one item at a falling edge, hold it until it is accepted and the
    // unit is no longer busy.
    task automatic issue(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) @(negedge i_clk);
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic issue_random();
        if ($urandom_range(0, 99) < 20)
            issue(make_row(2'($urandom), rand_word(), rand_word(), rand_word(), rand_word()));
        else
            issue(make_box(rand_word(), rand_word(), rand_word(),
                           rand_half(), rand_half(), rand_half()));
    endtask

    initial begin
        start    = 1'b0;
        i_item   = '0;
        i_rst_n  = 1'b0;
        idle_pct = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: box through the all-zero matrix after reset.
        issue(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000,
                       31'h7FFF_FFFF, 31'h0, 31'h1_0000));
        // Identity with translation.
        issue(make_row(2'd0, 32'h1_0000, 32'h0, 32'h0, 32'h5_0000));
        issue(make_row(2'd1, 32'h0, 32'h1_0000, 32'h0, 32'hFFFB_0000));
        issue(make_row(2'd2, 32'h0, 32'h0, 32'h1_0000, 32'h0));
        issue(make_box(32'h2_0000, 32'hFFFF_8000, 32'h0,
                       31'h1_0000, 31'h2_0000, 31'h3_0000));
        issue(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        // Out-of-range row is ignored.
        issue(make_row(2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        issue(make_box(32'h1, 32'hFFFF_FFFF, 32'h0, 31'h1, 31'h1, 31'h1));
        // Extreme negative coefficients: floor rounding and saturation.
        issue(make_row(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        issue(make_row(2'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        issue(make_row(2'd2, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000, 32'h0));
        issue(make_box(32'h1, 32'hFFFF_FFFF, 32'h3, 31'h1, 31'h7FFF, 31'h1_8000));
        issue(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        issue(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       31'd0, 31'd0, 31'd0));
        issue(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       31'h5555_5555, 31'h2AAA_AAAA, 31'h0));

        // Random phases: sender busy, then lightly loaded, then back to back.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 37 : (phase == 1) ? 80 : 0;
            for (int n = 0; n < 550; n++) begin
                issue_random();
                // Pause now and then until the unit has drained.
                if (n % 200 == 100)
                    while (pending != 0) @(negedge i_clk);
            end
        end

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
